@@ rtl/core/dtr_pkg.sv @@
`timescale 1ns / 1ps

package dtr_pkg;

    localparam int FRAC_BITS = 16;

    // shared divider geometry
    localparam int NUM_W  = 68;
    localparam int DEN_W  = 64;
    localparam int ITER_W = 7;

    localparam logic [ITER_W-1:0] IT_RATE   = 7'd64;
    localparam logic [ITER_W-1:0] IT_WEIGHT = 7'd33;
    localparam logic [ITER_W-1:0] IT_REF    = 7'd68;

    localparam logic [NUM_W-1:0] TEN_SHIFT  = 68'd10 << (2 * FRAC_BITS);
    localparam logic [NUM_W-1:0] WEIGHT_ONE = 68'h1_0000_0000;
    localparam logic [40:0]      SAT_CAP    = 41'h100_0000_0000;

    localparam logic [7:0] REG_DRAG   = 8'd0;
    localparam logic [7:0] REG_HEIGHT = 8'd1;
    localparam logic [7:0] REG_SOIL   = 8'd2;
    localparam logic [7:0] REG_COUNT  = 8'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CELL = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_OP, S_SQ_MUL, S_SQ_ACC, S_RT, S_RT_WAIT,
        S_RATE_CMP, S_RATE_W1, S_RATE_T, S_RATE_W2,
        S_PT_INIT, S_PT_RD, S_PT_DIFF, S_W_DIV, S_W_WAIT, S_W_MUL, S_W_ACC,
        S_REF_DIV, S_REF_WAIT, S_DIFF,
        S_M1_OP, S_M1_MUL, S_M1_ACC, S_M2_OP, S_M2_MUL, S_M2_ACC, S_CAP, S_RES
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [30:0]        temp;
    } pt_t;

endpackage

@@ rtl/core/dtr_if.sv @@
`timescale 1ns / 1ps

interface dtr_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [3:0]         point_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        temperature;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [16:0]        blank_weight;
    logic signed [31:0] src_in;

    modport source (
        output valid, command, point_index, pos_x, pos_y, pos_z, temperature,
               vel_x, vel_y, vel_z, blank_weight, src_in,
        input  ready
    );
    modport sink (
        input  valid, command, point_index, pos_x, pos_y, pos_z, temperature,
               vel_x, vel_y, vel_z, blank_weight, src_in,
        output ready
    );
endinterface

interface dtr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] src_out;
    logic [30:0]        ref_temperature;

    modport source (output valid, src_out, ref_temperature, input ready);
    modport sink (input valid, src_out, ref_temperature, output ready);
endinterface

interface dtr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/dtr_sqrt.sv @@
`timescale 1ns / 1ps

module dtr_sqrt
    import dtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output unit_stat_t  stat,
    output logic [31:0] root
);

    logic [63:0] v_reg;
    logic [35:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [35:0] rem_try;
    logic [35:0] trial;
    logic        ge;

    // two radicand bits per step
    assign rem_try = {rem_reg[33:0], v_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = rem_try >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[61:0], 2'b00};
            rem_reg  <= ge ? rem_try - trial : rem_try;
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

@@ rtl/core/dtr_div.sv @@
`timescale 1ns / 1ps

module dtr_div
    import dtr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [ITER_W-1:0] iters,
    output unit_stat_t        stat,
    output logic [NUM_W-1:0]  quo
);

    logic [NUM_W-1:0]  sh_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    rem_try;
    logic              ge;

    // restoring divider, one quotient bit per cycle
    assign rem_try = {rem_reg, sh_reg[NUM_W-1]};
    assign ge      = rem_try >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - ITER_W'(1);
                if (cnt_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // only the low iters bits of num matter; left-align them
            sh_reg  <= num << (ITER_W'(NUM_W) - iters);
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? DEN_W'(rem_try - {1'b0, den_reg}) : rem_try[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

@@ rtl/core/drag_temperature_relaxation_idw.sv @@
`timescale 1ns / 1ps

// Drag temperature relaxation with inverse distance weighted reference.
// in_ch: one command per transfer. A load (command 0) writes pos_x/y/z and
// temperature into table slot point_index and completes with
// no result. A cell (command 1) yields one transfer on out_ch carrying the
// updated source value and the reference temperature used.
// cfg: register writes (0 drag coefficient, 1 cell height, 2 soil
// temperature, 3 point count), ready and taken only while idle.
// A cell runs on one shared multiplier, one bit-serial square root unit
// and one bit-serial divider; each point in use takes one square root
// and one weight division, and the rate takes one division instead of two
// when the drag limit applies. in_ch is not ready while a cell is in work.
// The result sits in an output register; the next item is taken while it
// waits, and a following cell holds in its last step until out_ch takes
// the earlier one.
// Reset clears control state and the registers to their defaults; the
// point table has no reset and must be loaded before use.
module drag_temperature_relaxation_idw
    import dtr_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    dtr_in_if.sink    in_ch,
    dtr_out_if.source out_ch,
    dtr_cfg_if.sink   cfg
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW = (AW > 4) ? AW : 4;

    state_t state_reg, state_next;

    logic [30:0] cd_reg, dz_reg, soil_reg;
    logic [4:0]  cnt_reg;

    logic signed [31:0] cx_reg, cy_reg, cz_reg, src_reg;
    logic [30:0]        tc_reg;
    logic [16:0]        blank_reg;

    logic [32:0] m_reg [3];
    logic        half_reg;
    logic [1:0]  k_reg;
    logic [63:0] acc_reg;
    logic [33:0] norm_reg;
    logic        phase_reg;
    logic [63:0] rate_reg;
    logic [8:0]  n_reg;
    logic [AW-1:0] idx_reg;
    pt_t         rd_reg;
    pt_t         pt_mem [MAX_POINTS];
    logic [32:0] w_reg;
    logic [36:0] sw_reg;
    logic [67:0] num_reg;
    logic [30:0] ref_reg;
    logic [32:0] mul_a_reg, mul_b_reg;
    logic [65:0] prod_reg;
    logic [63:0] wa_reg;
    logic [32:0] wb_reg;
    logic [96:0] wide_reg;
    logic        stage_reg;
    logic [40:0] mg_reg;
    logic        neg_reg;

    logic               out_valid_reg;
    logic signed [31:0] src_out_reg;
    logic [30:0]        ref_out_reg;

    logic              in_fire, out_fire, out_free;
    logic              div_start, sqrt_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [ITER_W-1:0] div_iters;
    unit_stat_t        div_stat, sqrt_stat;
    logic [NUM_W-1:0]  div_quo;
    logic [31:0]       sqrt_root;

    logic [30:0] dz_eff;
    logic [34:0] spd1;
    logic        rate_big;
    logic [33:0] norm_val;
    logic [32:0] sq_op;
    logic [8:0]  n_calc;
    logic [IW-1:0] slot_ext;
    logic        slot_ok;
    logic [32:0] dm [3];
    logic [32:0] vm [3];
    logic [32:0] w_calc;
    logic signed [31:0] diff;
    logic [80:0] wide_sh;
    logic [40:0] cap_val;
    logic signed [42:0] res_full;
    logic signed [31:0] res_sat;
    logic        last_pt;

    function automatic logic [32:0] mag33(input logic signed [32:0] a);
        return a[32] ? 33'(-a) : 33'(a);
    endfunction

    assign in_fire  = in_ch.valid & in_ch.ready;
    assign out_fire = out_valid_reg & out_ch.ready;
    assign out_free = ~out_valid_reg | out_ch.ready;
    assign cfg.ready = state_reg == S_IDLE;

    assign dz_eff   = (dz_reg == '0) ? 31'd1 : dz_reg;
    assign spd1     = 35'(norm_reg) + 35'd1;
    assign rate_big = 39'(cd_reg) >= 39'(spd1) * 39'd10;
    assign norm_val = half_reg ? {1'b0, sqrt_root, 1'b0} : {2'b00, sqrt_root};
    assign sq_op    = half_reg ? (m_reg[k_reg] >> 1) : m_reg[k_reg];
    assign n_calc   = (9'(cnt_reg) > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : 9'(cnt_reg);
    assign slot_ext = IW'(in_ch.point_index);
    assign slot_ok  = 9'(in_ch.point_index) < 9'(MAX_POINTS);
    assign last_pt  = 9'(idx_reg) == n_reg - 9'd1;

    assign vm[0] = mag33(33'(in_ch.vel_x));
    assign vm[1] = mag33(33'(in_ch.vel_y));
    assign vm[2] = mag33(33'(in_ch.vel_z));
    assign dm[0] = mag33(33'(cx_reg) - 33'(rd_reg.x));
    assign dm[1] = mag33(33'(cy_reg) - 33'(rd_reg.y));
    assign dm[2] = mag33(33'(cz_reg) - 33'(rd_reg.z));

    assign w_calc  = (div_quo == '0) ? 33'd1 : div_quo[32:0];
    assign diff    = 32'({1'b0, tc_reg}) - 32'({1'b0, ref_reg});
    assign wide_sh = wide_reg[96:FRAC_BITS];
    assign cap_val = (wide_sh > 81'(SAT_CAP)) ? SAT_CAP : wide_sh[40:0];
    assign res_full = neg_reg ? 43'(src_reg) + 43'($signed({1'b0, mg_reg}))
                              : 43'(src_reg) - 43'($signed({1'b0, mg_reg}));
    always_comb
    begin
        if (res_full > 43'sd2147483647)
            res_sat = 32'sh7FFF_FFFF;
        else if (res_full < -43'sd2147483648)
            res_sat = 32'sh8000_0000;
        else
            res_sat = res_full[31:0];
    end

    // divider operand selection
    always_comb
    begin
        div_num   = WEIGHT_ONE;
        div_den   = DEN_W'(spd1);
        div_iters = IT_WEIGHT;
        unique case (state_reg)
            S_RATE_CMP:
            begin
                div_iters = IT_RATE;
                if (rate_big)
                begin
                    div_num = TEN_SHIFT;
                    div_den = DEN_W'(dz_eff);
                end
                else
                begin
                    div_num = NUM_W'(cd_reg) << FRAC_BITS;
                    div_den = DEN_W'(spd1);
                end
            end
            S_RATE_T:
            begin
                div_num   = NUM_W'(div_quo[46:0]) << FRAC_BITS;
                div_den   = DEN_W'(dz_eff);
                div_iters = IT_RATE;
            end
            S_REF_DIV:
            begin
                div_num   = num_reg;
                div_den   = DEN_W'(sw_reg);
                div_iters = IT_REF;
            end
            default:
            begin
                div_num   = WEIGHT_ONE;
                div_den   = DEN_W'(spd1);
                div_iters = IT_WEIGHT;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire && in_ch.command == CMD_CELL)
                    state_next = S_SQ_OP;
            S_SQ_OP:    state_next = S_SQ_MUL;
            S_SQ_MUL:   state_next = S_SQ_ACC;
            S_SQ_ACC:   state_next = (k_reg == 2'd2) ? S_RT : S_SQ_OP;
            S_RT:       state_next = S_RT_WAIT;
            S_RT_WAIT:
                if (sqrt_stat.done)
                    state_next = phase_reg ? S_W_DIV : S_RATE_CMP;
            S_RATE_CMP: state_next = rate_big ? S_RATE_W2 : S_RATE_W1;
            S_RATE_W1:
                if (div_stat.done)
                    state_next = S_RATE_T;
            S_RATE_T:   state_next = S_RATE_W2;
            S_RATE_W2:
                if (div_stat.done)
                    state_next = S_PT_INIT;
            S_PT_INIT:  state_next = (n_calc == '0) ? S_DIFF : S_PT_RD;
            S_PT_RD:    state_next = S_PT_DIFF;
            S_PT_DIFF:  state_next = S_SQ_OP;
            S_W_DIV:    state_next = S_W_WAIT;
            S_W_WAIT:
                if (div_stat.done)
                    state_next = S_W_MUL;
            S_W_MUL:    state_next = S_W_ACC;
            S_W_ACC:    state_next = last_pt ? S_REF_DIV : S_PT_RD;
            S_REF_DIV:  state_next = S_REF_WAIT;
            S_REF_WAIT:
                if (div_stat.done)
                    state_next = S_DIFF;
            S_DIFF:     state_next = S_M1_OP;
            S_M1_OP:    state_next = S_M1_MUL;
            S_M1_MUL:   state_next = S_M1_ACC;
            S_M1_ACC:   state_next = S_M2_OP;
            S_M2_OP:    state_next = S_M2_MUL;
            S_M2_MUL:   state_next = S_M2_ACC;
            S_M2_ACC:   state_next = S_CAP;
            S_CAP:      state_next = stage_reg ? S_RES : S_M1_OP;
            S_RES:
                if (out_free)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ch.ready = state_reg == S_IDLE;
        sqrt_start  = state_reg == S_RT;
        div_start   = (state_reg == S_RATE_CMP) || (state_reg == S_RATE_T) ||
                      (state_reg == S_W_DIV) || (state_reg == S_REF_DIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cd_reg        <= '0;
            dz_reg        <= 31'd65536;
            soil_reg      <= 31'd19660800;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_RES && out_free)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_DRAG:   cd_reg   <= cfg.data[30:0];
                    REG_HEIGHT: dz_reg   <= cfg.data[30:0];
                    REG_SOIL:   soil_reg <= cfg.data[30:0];
                    REG_COUNT:  cnt_reg  <= cfg.data[4:0];
                    default:    ;
                endcase
            end
        end
    end

    // point table
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.command == CMD_LOAD && slot_ok)
            pt_mem[slot_ext[AW-1:0]] <= '{x: in_ch.pos_x, y: in_ch.pos_y,
                                          z: in_ch.pos_z, temp: in_ch.temperature};
        rd_reg <= pt_mem[idx_reg];
    end

    // shared multiplier, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a_reg * mul_b_reg;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    cx_reg    <= in_ch.pos_x;
                    cy_reg    <= in_ch.pos_y;
                    cz_reg    <= in_ch.pos_z;
                    tc_reg    <= in_ch.temperature;
                    blank_reg <= in_ch.blank_weight;
                    src_reg   <= in_ch.src_in;
                    m_reg     <= vm;
                    half_reg  <= vm[0][32] | vm[0][31] | vm[1][32] | vm[1][31] |
                                 vm[2][32] | vm[2][31];
                    k_reg     <= '0;
                    acc_reg   <= '0;
                    phase_reg <= 1'b0;
                end
            S_SQ_OP:
            begin
                mul_a_reg <= sq_op;
                mul_b_reg <= sq_op;
            end
            S_SQ_ACC:
            begin
                acc_reg <= acc_reg + prod_reg[63:0];
                k_reg   <= k_reg + 2'd1;
            end
            S_RT_WAIT:
                if (sqrt_stat.done)
                    norm_reg <= norm_val;
            S_RATE_W2:
                if (div_stat.done)
                    rate_reg <= div_quo[63:0];
            S_PT_INIT:
            begin
                n_reg   <= n_calc;
                idx_reg <= '0;
                sw_reg  <= '0;
                num_reg <= '0;
                ref_reg <= soil_reg;
            end
            S_PT_DIFF:
            begin
                m_reg     <= dm;
                half_reg  <= dm[0][32] | dm[0][31] | dm[1][32] | dm[1][31] |
                             dm[2][32] | dm[2][31];
                k_reg     <= '0;
                acc_reg   <= '0;
                phase_reg <= 1'b1;
            end
            S_W_WAIT:
                if (div_stat.done)
                begin
                    w_reg     <= w_calc;
                    mul_a_reg <= w_calc;
                    mul_b_reg <= 33'(rd_reg.temp);
                end
            S_W_ACC:
            begin
                sw_reg  <= sw_reg + 37'(w_reg);
                num_reg <= num_reg + 68'(prod_reg);
                if (!last_pt)
                    idx_reg <= idx_reg + AW'(1);
            end
            S_REF_WAIT:
                if (div_stat.done)
                    ref_reg <= div_quo[30:0];
            S_DIFF:
            begin
                neg_reg   <= diff[31];
                wa_reg    <= rate_reg;
                wb_reg    <= diff[31] ? 33'(-diff) : 33'(diff);
                stage_reg <= 1'b0;
            end
            S_M1_OP:
            begin
                mul_a_reg <= 33'(wa_reg[31:0]);
                mul_b_reg <= wb_reg;
            end
            S_M1_ACC: wide_reg <= 97'(prod_reg);
            S_M2_OP:
            begin
                mul_a_reg <= 33'(wa_reg[63:32]);
                mul_b_reg <= wb_reg;
            end
            S_M2_ACC: wide_reg <= wide_reg + (97'(prod_reg) << 32);
            S_CAP:
                if (stage_reg)
                    mg_reg <= cap_val;
                else
                begin
                    wa_reg    <= 64'(cap_val);
                    wb_reg    <= 33'(blank_reg);
                    stage_reg <= 1'b1;
                end
            S_RES:
                if (out_free)
                begin
                    src_out_reg <= res_sat;
                    ref_out_reg <= ref_reg;
                end
            default: ;
        endcase
    end

    dtr_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (acc_reg),
        .stat  (sqrt_stat),
        .root  (sqrt_root)
    );

    dtr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .iters (div_iters),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.src_out         = src_out_reg;
    assign out_ch.ref_temperature = ref_out_reg;

`ifndef SYNTHESIS
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");
    a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_stat.busy)
        else $error("square root started while busy");
    a_sw_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REF_DIV |-> sw_reg != '0)
        else $error("weight sum is zero at reference division");
    a_w_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_W_ACC |-> w_reg != '0)
        else $error("zero point weight");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RES && !out_free |=> state_reg == S_RES)
        else $error("result dropped under stall");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import dtr_pkg::*;

    typedef struct {
        logic               cmd;
        logic [3:0]         idx;
        logic signed [31:0] px, py, pz;
        logic [30:0]        temp;
        logic signed [31:0] vx, vy, vz;
        logic [16:0]        blank;
        logic signed [31:0] src;
    } relax_cmd_t;

    typedef struct {
        logic signed [31:0] src;
        logic [30:0]        reftemp;
    } relax_res_t;

    localparam int NPTS       = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYC   = 2000;

    logic clk;
    logic rst_n;

    dtr_in_if  in_ch ();
    dtr_out_if out_ch ();
    dtr_cfg_if cfg ();

    drag_temperature_relaxation_idw dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // predictor copy of registers and point table
    logic [63:0]        drag_cd;
    logic [63:0]        height_dz;
    logic [63:0]        soil_t;
    logic [4:0]         npts_cfg;
    logic signed [31:0] tab_x [NPTS];
    logic signed [31:0] tab_y [NPTS];
    logic signed [31:0] tab_z [NPTS];
    logic [30:0]        tab_t [NPTS];

    relax_cmd_t pending_cmds [$];
    relax_res_t expected_res [$];

    int send_idle;
    int recv_idle;
    int errors;
    int cells_sent;
    int loads_sent;
    int results_seen;
    int quiet_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] norm3(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] c);
        logic [63:0] lim;
        lim = 64'd1 << 31;
        // far apart: halve components, double the root
        if (a >= lim || b >= lim || c >= lim)
            return 2 * int_sqrt((a >> 1) * (a >> 1) + (b >> 1) * (b >> 1) + (c >> 1) * (c >> 1));
        return int_sqrt(a * a + b * b + c * c);
    endfunction

    function automatic logic [63:0] abs64(input longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic [63:0] mul_fix_sat(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        logic [63:0]  r;
        p = 128'(a) * 128'(b);
        if (p[127:64] != 0)
            return 64'd1 << 40;
        r = p[63:0] >> FRAC_BITS;
        return r > (64'd1 << 40) ? (64'd1 << 40) : r;
    endfunction

    task automatic relax_predict(input relax_cmd_t c);
        logic [63:0]  speed, dzv, rate, t, d, w, sw, mg, reft;
        logic [127:0] acc;
        longint       diff, res;
        int           n;
        relax_res_t   e;
        if (c.cmd == CMD_LOAD)
        begin
            tab_x[c.idx] = c.px;
            tab_y[c.idx] = c.py;
            tab_z[c.idx] = c.pz;
            tab_t[c.idx] = c.temp;
            return;
        end
        speed = norm3(abs64(longint'(c.vx)), abs64(longint'(c.vy)), abs64(longint'(c.vz)));
        dzv = height_dz == 0 ? 64'd1 : height_dz;
        if (drag_cd >= 10 * (speed + 1))
            rate = (64'd10 << (2 * FRAC_BITS)) / dzv;
        else
        begin
            t = (drag_cd << FRAC_BITS) / (speed + 1);
            rate = (t << FRAC_BITS) / dzv;
        end
        n = npts_cfg > NPTS ? NPTS : int'(npts_cfg);
        if (n == 0)
            reft = soil_t;
        else
        begin
            sw = 0;
            acc = 0;
            for (int i = 0; i < n; i++)
            begin
                d = norm3(abs64(longint'(c.px) - longint'(tab_x[i])),
                          abs64(longint'(c.py) - longint'(tab_y[i])),
                          abs64(longint'(c.pz) - longint'(tab_z[i])));
                w = (64'd1 << 32) / (d + 1);
                if (w == 0)
                    w = 1;
                sw = sw + w;
                acc = acc + 128'(w) * 128'(tab_t[i]);
            end
            reft = 64'(acc / 128'(sw));
        end
        reft = reft & 64'h7FFF_FFFF;
        diff = longint'(c.temp) - longint'(reft);
        mg = mul_fix_sat(mul_fix_sat(rate, abs64(diff)), 64'(c.blank));
        res = longint'(c.src) - (diff < 0 ? -longint'(mg) : longint'(mg));
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        e.src = res[31:0];
        e.reftemp = reft[30:0];
        expected_res.push_back(e);
    endtask

    // sender side
    always @(posedge clk or negedge rst_n)
    begin
        relax_cmd_t c;
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.command      <= CMD_LOAD;
            in_ch.point_index  <= '0;
            in_ch.pos_x        <= '0;
            in_ch.pos_y        <= '0;
            in_ch.pos_z        <= '0;
            in_ch.temperature  <= '0;
            in_ch.vel_x        <= '0;
            in_ch.vel_y        <= '0;
            in_ch.vel_z        <= '0;
            in_ch.blank_weight <= '0;
            in_ch.src_in       <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                c.cmd = in_ch.command;
                c.idx = in_ch.point_index;
                c.px = in_ch.pos_x;
                c.py = in_ch.pos_y;
                c.pz = in_ch.pos_z;
                c.temp = in_ch.temperature;
                c.vx = in_ch.vel_x;
                c.vy = in_ch.vel_y;
                c.vz = in_ch.vel_z;
                c.blank = in_ch.blank_weight;
                c.src = in_ch.src_in;
                relax_predict(c);
                if (c.cmd == CMD_CELL)
                    cells_sent++;
                else
                    loads_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    c = pending_cmds.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.command      <= c.cmd;
                    in_ch.point_index  <= c.idx;
                    in_ch.pos_x        <= c.px;
                    in_ch.pos_y        <= c.py;
                    in_ch.pos_z        <= c.pz;
                    in_ch.temperature  <= c.temp;
                    in_ch.vel_x        <= c.vx;
                    in_ch.vel_y        <= c.vy;
                    in_ch.vel_z        <= c.vz;
                    in_ch.blank_weight <= c.blank;
                    in_ch.src_in       <= c.src;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver side and result check
    always @(posedge clk or negedge rst_n)
    begin
        relax_res_t e;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_res.size() == 0)
                begin
                    $display("%0t: unexpected result src_out=%h ref=%h", $time,
                             out_ch.src_out, out_ch.ref_temperature);
                    errors++;
                end
                else
                begin
                    e = expected_res.pop_front();
                    if (out_ch.src_out !== e.src)
                    begin
                        $display("%0t: src_out expected %h actual %h", $time, e.src,
                                 out_ch.src_out);
                        errors++;
                    end
                    if (out_ch.ref_temperature !== e.reftemp)
                    begin
                        $display("%0t: ref_temperature expected %h actual %h", $time,
                                 e.reftemp, out_ch.ref_temperature);
                        errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            REG_DRAG:   drag_cd = 64'(val[30:0]);
            REG_HEIGHT: height_dz = 64'(val[30:0]);
            REG_SOIL:   soil_t = 64'(val[30:0]);
            REG_COUNT:  npts_cfg = val[4:0];
            default:    ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] cd, input logic [31:0] dz,
                            input logic [31:0] soil, input logic [31:0] cnt);
        write_reg(REG_DRAG, cd);
        write_reg(REG_HEIGHT, dz);
        write_reg(REG_SOIL, soil);
        write_reg(REG_COUNT, cnt);
    endtask

    // wait for everything sent and answered, then let any load finish
    task automatic drain();
        while (pending_cmds.size() != 0 || in_ch.valid || expected_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_val();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097152)) - 1048576);
            2: return 32'($signed($urandom_range(33554432)) - 16777216);
            3: return 32'($signed($urandom_range(400000)) - 200000);
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic relax_cmd_t make_cmd(input logic cmd, input logic [3:0] idx,
                                            input logic [31:0] p, input logic [30:0] tp,
                                            input logic [31:0] v, input logic [16:0] bw,
                                            input logic [31:0] s);
        relax_cmd_t c;
        c.cmd = cmd; c.idx = idx;
        c.px = p; c.py = p; c.pz = p;
        c.temp = tp;
        c.vx = v; c.vy = v; c.vz = v;
        c.blank = bw; c.src = s;
        return c;
    endfunction

    function automatic relax_cmd_t rand_cmd();
        relax_cmd_t c;
        c.cmd   = ($urandom_range(99) < 30) ? CMD_LOAD : CMD_CELL;
        c.idx   = $urandom_range(15);
        c.px    = pick_val();
        c.py    = pick_val();
        c.pz    = pick_val();
        c.temp  = $urandom_range(3) == 0 ? 31'($urandom) :
                  31'(19660800 + $signed($urandom_range(6553600)) - 3276800);
        c.vx    = pick_val();
        c.vy    = pick_val();
        c.vz    = pick_val();
        c.blank = $urandom_range(4) == 0 ? 17'($urandom) : 17'($urandom_range(65536));
        c.src   = pick_val();
        return c;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) pending_cmds.push_back(rand_cmd());
        drain();
    endtask

    initial
    begin
        drag_cd = 0;
        height_dz = 64'd1 << 16;
        soil_t = 64'd19660800;
        npts_cfg = 0;
        errors = 0;
        cells_sent = 0;
        loads_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        send_idle = 19;
        recv_idle = 64;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // constant reference mode, first with reset registers, then with extreme ones
        pending_cmds.push_back(make_cmd(CMD_CELL, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CELL, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                                        32'h8000_0000, 17'h1FFFF, 32'h8000_0000));
        drain();
        set_regs(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0);
        pending_cmds.push_back(make_cmd(CMD_CELL, 0, 32'h8000_0000, 31'h0, 32'h7FFF_FFFF,
                                        17'd65536, 32'h7FFF_FFFF));
        pending_cmds.push_back(make_cmd(CMD_CELL, 0, 0, 31'h7FFF_FFFF, 0, 17'h1FFFF,
                                        32'h8000_0000));
        pending_cmds.push_back(make_cmd(CMD_CELL, 0, 0, 31'd100, 32'h0000_0001, 17'd0, 0));
        // fill the whole table before any weighted cell
        for (int i = 0; i < NPTS; i++)
            pending_cmds.push_back(make_cmd(CMD_LOAD, 4'(i),
                                            (i % 4 == 0) ? 32'h7FFF_FFFF :
                                            (i % 4 == 1) ? 32'h8000_0000 :
                                            32'(i * 65536 - 500000),
                                            (i == 0) ? 31'h7FFF_FFFF : 31'(i * 1310720), 0, 0, 0));
        drain();
        // count above table size, far apart positions
        set_regs(32'd655360, 32'd1, 32'd0, 32'd31);
        pending_cmds.push_back(make_cmd(CMD_CELL, 0, 32'h8000_0000, 31'd19660800,
                                        32'h0001_0000, 17'd65536, 0));
        pending_cmds.push_back(make_cmd(CMD_CELL, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                                        32'h8000_0000, 17'h1FFFF, 32'h7FFF_FFFF));
        pending_cmds.push_back(make_cmd(CMD_CELL, 0, 32'd65536, 31'd0, 32'h0000_8000,
                                        17'd32768, 32'h8000_0000));
        drain();

        set_regs(32'd32768, 32'd65536, 32'd19660800, 32'd2);
        random_phase(150);
        set_regs(32'h7FFF_FFFF, 32'd16384, 32'd0, 32'd0);
        random_phase(150);
        send_idle = 64;
        recv_idle = 19;
        set_regs(32'd6553, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd4);
        random_phase(150);
        set_regs(32'd0, 32'd1, 32'd19660800, 32'd1);
        random_phase(150);
        send_idle = 0;
        recv_idle = 0;
        set_regs(32'd655360, 32'd131072, 32'd19660800, 32'd16);
        random_phase(100);
        set_regs(32'd1000000, 32'd0, 32'd100, 32'd3);
        random_phase(150);

        $display("tb: %0d cells and %0d table loads sent, %0d results checked,", cells_sent,
                 loads_sent, results_seen);
        $display("tb: point counts 0 to 31, extreme register values and three stall mixes");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ drag_temperature_relaxation_idw.f @@
rtl/core/dtr_pkg.sv
rtl/core/dtr_if.sv
rtl/core/dtr_sqrt.sv
rtl/core/dtr_div.sv
rtl/core/drag_temperature_relaxation_idw.sv
verif/tb.sv
